/* design/clr_pkg.sv */
package clr_pkg;

  // Default widths for the coordinate and color paths.
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS_DEF = 8;

  // Fixed widths of the signed endpoint fields and the canvas size registers.
  localparam int unsigned IN_COORD_BITS = 16;
  localparam int unsigned WIDE_BITS     = IN_COORD_BITS + 1;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned CFG_IDX_BITS  = 1;

  // Canvas size after reset.
  localparam logic [CFG_DATA_BITS-1:0] CANVAS_WIDTH_RST  = 13'd320;
  localparam logic [CFG_DATA_BITS-1:0] CANVAS_HEIGHT_RST = 13'd240;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_e;

  // Request types.
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

endpackage

/* design/clamped_line_rasterizer_core.sv */
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------------------
// in       | in_valid_i / in_stall_o | req_type, start_x/y, end_x/y, line_color
// out      | out_valid_o/out_stall_i | pixel_valid, pixel_x/y, pixel_color, last_pixel
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Every request yields one registered result, and one request can be accepted
// in every cycle while in_stall_o is low. The clamp, setup and Bresenham step
// all sit between the input port and the result register. A skid entry behind
// the result register lets the block take one more request while a result is
// stalled; in_stall_o rises only when that skid entry is occupied. Reset leaves
// the block idle with a 320 by 240 canvas.
module clamped_line_rasterizer_core
  import clr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [IN_COORD_BITS-1:0] start_x_i,
  input  logic [IN_COORD_BITS-1:0] start_y_i,
  input  logic [IN_COORD_BITS-1:0] end_x_i,
  input  logic [IN_COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]    line_color_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     pixel_valid_o,
  output logic [COORD_BITS-1:0]    pixel_x_o,
  output logic [COORD_BITS-1:0]    pixel_y_o,
  output logic [COLOR_BITS-1:0]    pixel_color_o,
  output logic                     last_pixel_o
);

  localparam int unsigned ERR_BITS = COORD_BITS + 2;
  localparam logic [WIDE_BITS-1:0] CANVAS_CAP = WIDE_BITS'(1) << COORD_BITS;

  // Largest legal coordinate for a canvas size: zero acts as one, and sizes
  // beyond the coordinate range saturate.
  function automatic logic [COORD_BITS-1:0] limit_of(input logic [CFG_DATA_BITS-1:0] size);
    logic [WIDE_BITS-1:0] size_ext;
    begin
      size_ext = WIDE_BITS'(size);
      if (size_ext == '0) begin
        limit_of = '0;
      end else if (size_ext > CANVAS_CAP) begin
        limit_of = COORD_BITS'(CANVAS_CAP - WIDE_BITS'(1));
      end else begin
        limit_of = COORD_BITS'(size_ext - WIDE_BITS'(1));
      end
    end
  endfunction

  // Clamp a signed endpoint into 0..hi.
  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [IN_COORD_BITS-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
    begin
      if (v[IN_COORD_BITS-1]) begin
        clamp_coord = '0;
      end else if (WIDE_BITS'(v) > WIDE_BITS'(hi)) begin
        clamp_coord = hi;
      end else begin
        clamp_coord = COORD_BITS'(v);
      end
    end
  endfunction

  // Canvas size registers.
  logic [CFG_DATA_BITS-1:0] canvas_width_q, canvas_height_q;

  // Line state.
  logic                       busy_q, busy_d;
  logic [COORD_BITS-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]      goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [COORD_BITS-1:0]      delta_x_q, delta_x_d, delta_y_q, delta_y_d;
  logic                       step_x_neg_q, step_x_neg_d, step_y_neg_q, step_y_neg_d;
  logic signed [ERR_BITS-1:0] error_term_q, error_term_d;
  logic [COLOR_BITS-1:0]      held_color_q, held_color_d;

  // Result computed for the request at the input.
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [COLOR_BITS-1:0] res_color;
  logic                  res_last;

  // Result register and skid entry.
  logic                  out_valid_q, out_valid_d;
  logic                  out_pix_q, out_pix_d, out_last_q, out_last_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [COLOR_BITS-1:0] out_color_q, out_color_d;
  logic                  skid_valid_q, skid_valid_d;
  logic                  skid_pix_q, skid_pix_d, skid_last_q, skid_last_d;
  logic [COORD_BITS-1:0] skid_x_q, skid_x_d, skid_y_q, skid_y_d;
  logic [COLOR_BITS-1:0] skid_color_q, skid_color_d;

  logic in_fire, out_fire;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= CANVAS_WIDTH_RST;
      canvas_height_q <= CANVAS_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i;
        REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line setup on load, one Bresenham step on tick while a line is in progress.
  always_comb begin
    logic [COORD_BITS-1:0]      hx, hy, sx, sy, ex, ey, dx, dy;
    logic signed [ERR_BITS-1:0] dx_s, dy_s, err_nx;
    logic                       move_x, move_y, last;
    logic [COORD_BITS-1:0]      nx, ny;

    busy_d       = busy_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    goal_x_d     = goal_x_q;
    goal_y_d     = goal_y_q;
    delta_x_d    = delta_x_q;
    delta_y_d    = delta_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    error_term_d = error_term_q;
    held_color_d = held_color_q;

    res_valid = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_color = '0;
    res_last  = 1'b0;
    last      = 1'b0;

    // Setup path.
    hx = limit_of(canvas_width_q);
    hy = limit_of(canvas_height_q);
    sx = clamp_coord(start_x_i, hx);
    sy = clamp_coord(start_y_i, hy);
    ex = clamp_coord(end_x_i, hx);
    ey = clamp_coord(end_y_i, hy);
    dx = (ex > sx) ? (ex - sx) : (sx - ex);
    dy = (ey > sy) ? (ey - sy) : (sy - ey);

    // Step path.
    dx_s   = signed'(ERR_BITS'(delta_x_q));
    dy_s   = signed'(ERR_BITS'(delta_y_q));
    move_x = error_term_q > -dx_s;
    move_y = error_term_q < dy_s;
    err_nx = error_term_q;
    nx     = cur_x_q;
    ny     = cur_y_q;
    if (move_x) begin
      err_nx = err_nx - dy_s;
      nx     = step_x_neg_q ? (cur_x_q - COORD_BITS'(1)) : (cur_x_q + COORD_BITS'(1));
    end
    if (move_y) begin
      err_nx = err_nx + dx_s;
      ny     = step_y_neg_q ? (cur_y_q - COORD_BITS'(1)) : (cur_y_q + COORD_BITS'(1));
    end

    if (req_type_e'(req_type_i) == REQ_LOAD) begin
      last         = (sx == ex) && (sy == ey);
      cur_x_d      = sx;
      cur_y_d      = sy;
      goal_x_d     = ex;
      goal_y_d     = ey;
      delta_x_d    = dx;
      delta_y_d    = dy;
      step_x_neg_d = !(sx < ex);
      step_y_neg_d = !(sy < ey);
      // Half the dominant delta, rounded toward zero.
      error_term_d = (dx > dy) ? signed'(ERR_BITS'(dx >> 1))
                               : -signed'(ERR_BITS'(dy >> 1));
      held_color_d = line_color_i;
      busy_d       = !last;
      res_valid    = 1'b1;
      res_x        = sx;
      res_y        = sy;
      res_color    = line_color_i;
      res_last     = last;
    end else if (busy_q) begin
      last         = (nx == goal_x_q) && (ny == goal_y_q);
      cur_x_d      = nx;
      cur_y_d      = ny;
      error_term_d = err_nx;
      busy_d       = !last;
      res_valid    = 1'b1;
      res_x        = nx;
      res_y        = ny;
      res_color    = held_color_q;
      res_last     = last;
    end
  end

  // Line state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      delta_x_q    <= '0;
      delta_y_q    <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      error_term_q <= '0;
      held_color_q <= '0;
    end else if (in_fire) begin
      busy_q       <= busy_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      goal_x_q     <= goal_x_d;
      goal_y_q     <= goal_y_d;
      delta_x_q    <= delta_x_d;
      delta_y_q    <= delta_y_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      error_term_q <= error_term_d;
      held_color_q <= held_color_d;
    end
  end

  // Result register refill from the skid entry or the input, else park in skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pix_d    = out_pix_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    skid_pix_d   = skid_pix_q;
    skid_x_d     = skid_x_q;
    skid_y_d     = skid_y_q;
    skid_color_d = skid_color_q;
    skid_last_d  = skid_last_q;

    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pix_d    = skid_pix_q;
        out_x_d      = skid_x_q;
        out_y_d      = skid_y_q;
        out_color_d  = skid_color_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end else if (in_fire) begin
        out_valid_d = 1'b1;
        out_pix_d   = res_valid;
        out_x_d     = res_x;
        out_y_d     = res_y;
        out_color_d = res_color;
        out_last_d  = res_last;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_pix_d   = res_valid;
      skid_x_d     = res_x;
      skid_y_d     = res_y;
      skid_color_d = res_color;
      skid_last_d  = res_last;
    end
  end

  // Output valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    out_pix_q    <= out_pix_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_color_q  <= out_color_d;
    out_last_q   <= out_last_d;
    skid_pix_q   <= skid_pix_d;
    skid_x_q     <= skid_x_d;
    skid_y_q     <= skid_y_d;
    skid_color_q <= skid_color_d;
    skid_last_q  <= skid_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = out_pix_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_pixel_o  = out_last_q;

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int COLOR_W     = COLOR_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 235;

  // Canvas sizes per random phase; the last phase picks its own size.
  localparam logic [CFG_DATA_BITS-1:0] PHASE_W [N_PHASES] =
    '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd17, 13'd640, 13'd2048, 13'd320};
  localparam logic [CFG_DATA_BITS-1:0] PHASE_H [N_PHASES] =
    '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd4097, 13'd480, 13'd3, 13'd240};

  typedef struct {
    req_type_e                       kind;
    logic signed [IN_COORD_BITS-1:0] sx;
    logic signed [IN_COORD_BITS-1:0] sy;
    logic signed [IN_COORD_BITS-1:0] ex;
    logic signed [IN_COORD_BITS-1:0] ey;
    logic [COLOR_W-1:0]              color;
  } line_req_t;

  typedef struct {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i   = 1'b0;
  logic [IN_COORD_BITS-1:0] start_x_i    = '0;
  logic [IN_COORD_BITS-1:0] start_y_i    = '0;
  logic [IN_COORD_BITS-1:0] end_x_i      = '0;
  logic [IN_COORD_BITS-1:0] end_y_i      = '0;
  logic [COLOR_W-1:0]       line_color_i = '0;

  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     pixel_valid_o;
  logic [COORD_W-1:0]       pixel_x_o;
  logic [COORD_W-1:0]       pixel_y_o;
  logic [COLOR_W-1:0]       pixel_color_o;
  logic                     last_pixel_o;

  // Requests waiting for the driver and pixels waiting for the monitor.
  line_req_t req_backlog[$];
  pixel_t    pixels_due[$];
  line_req_t on_port;
  pixel_t    due_px;

  // Shadow of the rasterizer state and of the canvas registers.
  logic [CFG_DATA_BITS-1:0] canvas_w = CANVAS_WIDTH_RST;
  logic [CFG_DATA_BITS-1:0] canvas_h = CANVAS_HEIGHT_RST;
  bit                       line_busy = 1'b0;
  int                       cur_x = 0, cur_y = 0, goal_x = 0, goal_y = 0;
  int                       delta_x = 0, delta_y = 0, err_acc = 0;
  bit                       neg_x = 1'b0, neg_y = 1'b0;
  logic [COLOR_W-1:0]       line_color_q = '0;

  int  n_errors = 0;
  int  n_queued = 0;
  int  n_loads = 0, n_steps = 0, n_idle_steps = 0, n_lines_done = 0, n_cfg_writes = 0;
  int  gap_left = 0, stall_left = 0, quiet_cycles = 0;
  bit  in_steady = 1'b0, out_steady = 1'b0;

  clamped_line_rasterizer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_color_i  (line_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

  always #2 clk_i = ~clk_i;

  // Highest coordinate allowed by a canvas size; zero acts as one and the
  // size saturates at the coordinate range.
  function automatic int canvas_limit(logic [CFG_DATA_BITS-1:0] size);
    int s;
    s = size;
    if (s == 0) s = 1;
    if (s > (1 << COORD_W)) s = 1 << COORD_W;
    return s - 1;
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expected pixel for one accepted request; updates the shadow state.
  function automatic pixel_t rasterize(line_req_t r);
    pixel_t p;
    int     hx, hy, old;
    p = '{valid: 1'b0, x: '0, y: '0, color: '0, last: 1'b0};
    if (r.kind == REQ_LOAD) begin
      hx = canvas_limit(canvas_w);
      hy = canvas_limit(canvas_h);
      cur_x   = clamp_to(int'(r.sx), hx);
      cur_y   = clamp_to(int'(r.sy), hy);
      goal_x  = clamp_to(int'(r.ex), hx);
      goal_y  = clamp_to(int'(r.ey), hy);
      delta_x = (goal_x > cur_x) ? goal_x - cur_x : cur_x - goal_x;
      delta_y = (goal_y > cur_y) ? goal_y - cur_y : cur_y - goal_y;
      neg_x   = !(cur_x < goal_x);
      neg_y   = !(cur_y < goal_y);
      err_acc = ((delta_x > delta_y) ? delta_x : -delta_y) / 2;
      line_color_q = r.color;
      line_busy = !(cur_x == goal_x && cur_y == goal_y);
    end else if (line_busy) begin
      old = err_acc;
      if (old > -delta_x) begin
        err_acc -= delta_y;
        cur_x += neg_x ? -1 : 1;
      end
      if (old < delta_y) begin
        err_acc += delta_x;
        cur_y += neg_y ? -1 : 1;
      end
      if (cur_x == goal_x && cur_y == goal_y) line_busy = 1'b0;
    end else begin
      // A step with no line in progress yields an empty result.
      return p;
    end
    p.valid = 1'b1;
    p.x     = cur_x[COORD_W-1:0];
    p.y     = cur_y[COORD_W-1:0];
    p.color = line_color_q;
    p.last  = (cur_x == goal_x && cur_y == goal_y);
    return p;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_length(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic add_request(req_type_e kind, int sx, int sy, int ex, int ey, int color);
    line_req_t r;
    r.kind  = kind;
    r.sx    = sx[IN_COORD_BITS-1:0];
    r.sy    = sy[IN_COORD_BITS-1:0];
    r.ex    = ex[IN_COORD_BITS-1:0];
    r.ey    = ey[IN_COORD_BITS-1:0];
    r.color = color[COLOR_W-1:0];
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // A step request carries random payload that the block must ignore.
  task automatic add_tick();
    add_request(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // One line: a load followed by steps that mostly run it to its end point;
  // some lines are cut short by the next load or overrun into idle steps.
  task automatic add_random_line();
    int hx, hy, sx, sy, ex, ey, span, steps, ticks, r;
    hx = canvas_limit(canvas_w);
    hy = canvas_limit(canvas_h);
    r  = $urandom_range(0, 99);
    if (r < 10) begin
      add_request(req_type_e'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      return;
    end
    if (r < 25) begin
      sx = $urandom_range(0, 65535) - 32768;
      sy = $urandom_range(0, 65535) - 32768;
      ex = $urandom_range(0, 65535) - 32768;
      ey = $urandom_range(0, 65535) - 32768;
    end else begin
      span = ($urandom_range(0, 9) == 0) ? 40 : 8;
      sx = $urandom_range(0, hx + 4) - 2;
      sy = $urandom_range(0, hy + 4) - 2;
      ex = sx + $urandom_range(0, 2 * span) - span;
      ey = sy + $urandom_range(0, 2 * span) - span;
    end
    add_request(REQ_LOAD, sx, sy, ex, ey, $urandom_range(0, 255));
    steps = clamp_to(ex, hx) - clamp_to(sx, hx);
    if (steps < 0) steps = -steps;
    span = clamp_to(ey, hy) - clamp_to(sy, hy);
    if (span < 0) span = -span;
    if (span > steps) steps = span;
    r = $urandom_range(0, 99);
    if (steps > 48)   ticks = $urandom_range(0, 48);
    else if (r < 75)  ticks = steps;
    else if (r < 88)  ticks = steps + $urandom_range(1, 3);
    else              ticks = $urandom_range(0, steps);
    repeat (ticks) add_tick();
  endtask

  // Wait until every request is accepted and every pixel has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || pixels_due.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Write both canvas registers back to back, keeping valid high between them.
  task automatic set_canvas(logic [CFG_DATA_BITS-1:0] width,
                            logic [CFG_DATA_BITS-1:0] height);
    for (int i = 0; i < 2; i++) begin
      cfg_index_i <= (i == 0) ? REG_CANVAS_WIDTH : REG_CANVAS_HEIGHT;
      cfg_data_i  <= (i == 0) ? width : height;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (i == 0) canvas_w = width;
      else        canvas_h = height;
      n_cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: presents queued requests, predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pixels_due.push_back(rasterize(on_port));
        if (on_port.kind == REQ_LOAD) n_loads++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (req_backlog.size() > 0) begin
          on_port = req_backlog.pop_front();
          req_type_i   <= on_port.kind;
          start_x_i    <= on_port.sx;
          start_y_i    <= on_port.sy;
          end_x_i      <= on_port.ex;
          end_y_i      <= on_port.ey;
          line_color_i <= on_port.color;
          in_valid_i   <= 1'b1;
          gap_left     <= idle_length(in_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if ($urandom_range(0, 199) == 0) in_steady <= !in_steady;
    end
  end

  // Monitor: checks each accepted pixel against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          report_error($sformatf("unexpected pixel at (%0d,%0d)", pixel_x_o, pixel_y_o));
        end else begin
          due_px = pixels_due.pop_front();
          compare_field("pixel_valid", pixel_valid_o, due_px.valid);
          compare_field("pixel_x", pixel_x_o, due_px.x);
          compare_field("pixel_y", pixel_y_o, due_px.y);
          compare_field("pixel_color", pixel_color_o, due_px.color);
          compare_field("last_pixel", last_pixel_o, due_px.last);
          if (!due_px.valid) n_idle_steps++;
          else n_steps++;
          if (due_px.last) n_lines_done++;
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (!out_steady && $urandom_range(0, 3) == 0) stall_left <= idle_length(1'b0);
      end
      if ($urandom_range(0, 199) == 0) out_steady <= !out_steady;
    end
  end

  // Watchdog: ends the run when no handshake completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                       target;
    logic [CFG_DATA_BITS-1:0] w, h;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines on the reset canvas.
    add_request(REQ_TICK, -1, -1, -1, -1, 255);               // step with no line
    add_request(REQ_LOAD, 0, 0, 0, 0, 0);                     // single-pixel line
    add_tick();
    add_request(REQ_LOAD, -32768, -32768, 32767, 32767, 255); // clamps to both corners
    repeat (3) add_tick();
    add_request(REQ_LOAD, 100, 50, 103, 50, 'hA5);            // abandons the open line
    repeat (3) add_tick();
    add_request(REQ_LOAD, 5, 5, 3, 2, 'h5A);                  // steep, both signs negative
    repeat (3) add_tick();
    add_request(REQ_LOAD, 400, -7, -1, 300, 'h3C);            // clamps on every side
    repeat (2) add_tick();
    add_request(REQ_LOAD, -5, 300, -1, 999, 'h0F);            // collapses after clamping
    add_request(REQ_LOAD, 2, 2, 4, 3, 'hC3);
    repeat (3) add_tick();                                    // last step finds no line

    // Random phases, each on its own canvas size.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      w = PHASE_W[ph];
      h = PHASE_H[ph];
      if (ph == N_PHASES - 1) begin
        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
      end
      set_canvas(w, h);
      target = n_queued + PHASE_ITEMS;
      // One diagonal that touches the top coordinate on both axes.
      if (ph == 0) begin
        add_request(REQ_LOAD, 4095, 3968, 3968, 4095, 'h81);
        repeat (127) add_tick();
      end
      while (n_queued < target) add_random_line();
    end
    wait_idle();

    if (pixels_due.size() != 0)
      report_error($sformatf("%0d pixels never arrived", pixels_due.size()));
    $display("Ran %0d requests: %0d line loads, %0d pixel steps, %0d steps with no line.",
             n_queued, n_loads, n_steps - n_loads, n_idle_steps);
    $display("%0d lines reached their end point; %0d canvas register writes.",
             n_lines_done, n_cfg_writes);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
